// File: src/pfa_pkg.sv
// Shared types and constants of the paged frame allocator.
// Used by pfa_divider and paged_frame_allocator; depends on nothing.
package pfa_pkg;

    localparam int BYTES_W = 20;
    localparam int FSIZE_W = 16;
    localparam int PID_W   = 16;
    localparam int FIM_W   = 8;
    localparam int QCNT_W  = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [15:0] FSIZE_RESET = 16'd4096;
    localparam logic [7:0]  FIM_RESET   = 8'd128;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_MEM = 2'd1;

    localparam logic REQ_CREATE = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_FRAMES = 3'd1;
    localparam logic [2:0] ST_TOO_BIG   = 3'd2;
    localparam logic [2:0] ST_TABLE_FULL = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RECOUNT,
        S_DIV,
        S_CHECK,
        S_ALLOC,
        S_FIND,
        S_FREE,
        S_SHIFT,
        S_DEL_RESP
    } pfa_state_t;

    typedef struct packed {
        logic               done;
        logic [BYTES_W-1:0] quot;
        logic [FSIZE_W-1:0] rem;
    } pfa_div_res_t;

endpackage

// File: src/pfa_divider.sv
// Restoring divider, one quotient bit per cycle, for bytes / frame size.
// Depends on pfa_pkg.
module pfa_divider
    import pfa_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [BYTES_W-1:0] dividend,
    input  logic [FSIZE_W-1:0] divisor,
    output pfa_div_res_t       res
);

    logic [BYTES_W-1:0] q_reg, q_next;
    logic [FSIZE_W-1:0] rem_reg, rem_next;
    logic [FSIZE_W-1:0] dvs_reg, dvs_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [FSIZE_W:0]   trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
    end

    always_comb begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, q_reg[BYTES_W-1]};
        if (start) begin
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // shift in one dividend bit, subtract when it fits
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = FSIZE_W'(trial - {1'b0, dvs_reg});
                q_next   = {q_reg[BYTES_W-2:0], 1'b1};
            end else begin
                rem_next = trial[FSIZE_W-1:0];
                q_next   = {q_reg[BYTES_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == QCNT_W'(BYTES_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign res.done = done_reg;
    assign res.quot = q_reg;
    assign res.rem  = rem_reg;

endmodule

// File: src/paged_frame_allocator.sv
// Top level of the paged frame allocator: sequencer, frame bitmap, owner and
// process table memories. Depends on pfa_pkg and pfa_divider.
//
//  channel  | handshake           | carries
//  ---------+---------------------+--------------------------------------------
//  s_       | s_valid / s_ready   | req_type, proc_id, proc_bytes
//  m_       | m_valid / m_ready   | status, frame_valid, frame_number,
//           |                     | frame_count, wasted_bytes, free_left, last
//  cfg_     | cfg_valid/cfg_ready | cfg_index (0 frame_size, 1 frames_in_memory),
//           |                     | cfg_data
//
// Create: the divider works out the frame count, a check state follows, then
//   frames are scanned up to the highest frame taken (plus any output stall).
// Delete: the table is searched entry by entry, all NUM_FRAMES frames are
//   visited (owner memory read for used frames), then later entries are compacted.
// A write of frames_in_memory recounts free frames over all NUM_FRAMES frames.
// Reset (synchronous, aresetn low) clears the bitmap and table count at once.
// The block takes no item while busy; a waiting result stalls the sequencer.
module paged_frame_allocator
    import pfa_pkg::*;
#(
    parameter int NUM_FRAMES      = 128,
    parameter int MAX_PROCS       = 64,
    parameter int FRAMES_PER_PROC = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [15:0]          s_proc_id,
    input  logic [19:0]          s_proc_bytes,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_status,
    output logic                 m_frame_valid,
    output logic [6:0]           m_frame_number,
    output logic [5:0]           m_frame_count,
    output logic [15:0]          m_wasted_bytes,
    output logic [7:0]           m_free_left,
    output logic                 m_last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    localparam int FW  = $clog2(NUM_FRAMES);
    localparam int CW  = $clog2(NUM_FRAMES + 1);
    localparam int PW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int PCW = $clog2(MAX_PROCS + 1);
    localparam int EFW = $clog2(FRAMES_PER_PROC + 1);
    localparam int IW  = (FW > PCW) ? FW : PCW;
    localparam int NW  = BYTES_W + 1;
    localparam int LW  = (CW > FIM_W) ? CW : FIM_W;

    pfa_state_t state_reg, state_next;

    // configuration
    logic [FSIZE_W-1:0] fsize_reg, fsize_next;
    logic [FIM_W-1:0]   fim_reg, fim_next;
    logic [CW-1:0]      lim;
    logic [FSIZE_W-1:0] fs_eff;

    // global state
    logic [NUM_FRAMES-1:0] in_use_reg, in_use_next;
    logic [PCW-1:0]        pcnt_reg, pcnt_next;
    logic [CW-1:0]         free_reg, free_next;

    // request context
    logic [PID_W-1:0]   pid_reg, pid_next;
    logic [NW-1:0]      frames_reg, frames_next;
    logic [FSIZE_W-1:0] waste_reg, waste_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic               ph_reg, ph_next;
    logic [EFW-1:0]     acnt_reg, acnt_next;
    logic [PW-1:0]      slot_reg, slot_next;
    logic [CW-1:0]      acc_reg, acc_next;

    // output register
    logic        mv_reg, mv_next;
    logic [2:0]  mst_reg, mst_next;
    logic        mfv_reg, mfv_next;
    logic [6:0]  mfn_reg, mfn_next;
    logic [5:0]  mfc_reg, mfc_next;
    logic [15:0] mwb_reg, mwb_next;
    logic [7:0]  mfl_reg, mfl_next;
    logic        mlast_reg, mlast_next;
    logic        out_free;

    // memories
    logic [PID_W-1:0]   pid_mem [MAX_PROCS];
    logic [EFW-1:0]     efr_mem [MAX_PROCS];
    logic [FSIZE_W-1:0] wst_mem [MAX_PROCS];
    logic [PW-1:0]      own_mem [NUM_FRAMES];
    logic [PID_W-1:0]   pid_rd_reg;
    logic [EFW-1:0]     efr_rd_reg;
    logic [FSIZE_W-1:0] wst_rd_reg;
    logic [PW-1:0]      own_rd_reg;
    logic               ent_we;
    logic [PW-1:0]      ent_wa, ent_ra;
    logic [PID_W-1:0]   ent_wpid;
    logic [EFW-1:0]     ent_wfr;
    logic [FSIZE_W-1:0] ent_wws;
    logic               own_we;
    logic [PW-1:0]      own_wd;
    logic [FW-1:0]      fidx;

    // divider
    logic         div_start;
    pfa_div_res_t div_res;
    logic         in_acc;

    pfa_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (s_proc_bytes),
        .divisor  (fs_eff),
        .res      (div_res)
    );

    assign lim    = (LW'(fim_reg) > LW'(NUM_FRAMES)) ? CW'(NUM_FRAMES) : CW'(fim_reg);
    assign fs_eff = (fsize_reg == '0) ? FSIZE_W'(1) : fsize_reg;
    assign fidx   = idx_reg[FW-1:0];
    assign ent_ra = (state_reg == S_SHIFT) ? PW'(idx_reg + 1'b1) : PW'(idx_reg);
    assign out_free = !mv_reg || m_ready;

    assign s_ready   = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_acc    = s_valid && s_ready;
    assign div_start = in_acc && (s_req_type == REQ_CREATE);

    assign m_valid        = mv_reg;
    assign m_status       = mst_reg;
    assign m_frame_valid  = mfv_reg;
    assign m_frame_number = mfn_reg;
    assign m_frame_count  = mfc_reg;
    assign m_wasted_bytes = mwb_reg;
    assign m_free_left    = mfl_reg;
    assign m_last         = mlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            fsize_reg  <= FSIZE_RESET;
            fim_reg    <= FIM_RESET;
            in_use_reg <= '0;
            pcnt_reg   <= '0;
            free_reg   <= (LW'(FIM_RESET) > LW'(NUM_FRAMES)) ? CW'(NUM_FRAMES)
                                                             : CW'(FIM_RESET);
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            fsize_reg  <= fsize_next;
            fim_reg    <= fim_next;
            in_use_reg <= in_use_next;
            pcnt_reg   <= pcnt_next;
            free_reg   <= free_next;
            mv_reg     <= mv_next;
        end
        pid_reg    <= pid_next;
        frames_reg <= frames_next;
        waste_reg  <= waste_next;
        idx_reg    <= idx_next;
        ph_reg     <= ph_next;
        acnt_reg   <= acnt_next;
        slot_reg   <= slot_next;
        acc_reg    <= acc_next;
        mst_reg    <= mst_next;
        mfv_reg    <= mfv_next;
        mfn_reg    <= mfn_next;
        mfc_reg    <= mfc_next;
        mwb_reg    <= mwb_next;
        mfl_reg    <= mfl_next;
        mlast_reg  <= mlast_next;
    end

    // process table
    always_ff @(posedge aclk) begin
        if (ent_we) begin
            pid_mem[ent_wa] <= ent_wpid;
            efr_mem[ent_wa] <= ent_wfr;
            wst_mem[ent_wa] <= ent_wws;
        end
        pid_rd_reg <= pid_mem[ent_ra];
        efr_rd_reg <= efr_mem[ent_ra];
        wst_rd_reg <= wst_mem[ent_ra];
    end

    // frame owner: table position of the process holding each used frame
    always_ff @(posedge aclk) begin
        if (own_we) begin
            own_mem[fidx] <= own_wd;
        end
        own_rd_reg <= own_mem[fidx];
    end

    always_comb begin
        state_next  = state_reg;
        fsize_next  = fsize_reg;
        fim_next    = fim_reg;
        in_use_next = in_use_reg;
        pcnt_next   = pcnt_reg;
        free_next   = free_reg;
        pid_next    = pid_reg;
        frames_next = frames_reg;
        waste_next  = waste_reg;
        idx_next    = idx_reg;
        ph_next     = ph_reg;
        acnt_next   = acnt_reg;
        slot_next   = slot_reg;
        acc_next    = acc_reg;
        mv_next     = mv_reg && !m_ready;
        mst_next    = mst_reg;
        mfv_next    = mfv_reg;
        mfn_next    = mfn_reg;
        mfc_next    = mfc_reg;
        mwb_next    = mwb_reg;
        mfl_next    = mfl_reg;
        mlast_next  = mlast_reg;
        ent_we      = 1'b0;
        ent_wa      = PW'(pcnt_reg);
        ent_wpid    = pid_reg;
        ent_wfr     = EFW'(frames_reg);
        ent_wws     = waste_reg;
        own_we      = 1'b0;
        own_wd      = slot_reg;

        case (state_reg)
            S_IDLE: begin
                if (cfg_valid) begin
                    if (cfg_index == CFG_FRAME_SIZE) begin
                        fsize_next = cfg_data;
                    end else if (cfg_index == CFG_FRAMES_MEM) begin
                        fim_next   = cfg_data[FIM_W-1:0];
                        idx_next   = '0;
                        acc_next   = '0;
                        state_next = S_RECOUNT;
                    end
                end else if (in_acc) begin
                    pid_next = s_proc_id;
                    idx_next = '0;
                    ph_next  = 1'b0;
                    state_next = (s_req_type == REQ_DELETE) ? S_FIND : S_DIV;
                end
            end

            S_RECOUNT: begin
                // count free frames below the new limit, one frame a cycle
                if ((CW'(fidx) < lim) && !in_use_reg[fidx]) begin
                    acc_next = acc_reg + 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (fidx == FW'(NUM_FRAMES - 1)) begin
                    free_next  = acc_next;
                    state_next = S_IDLE;
                end
            end

            S_DIV: begin
                if (div_res.done) begin
                    frames_next = NW'(div_res.quot) + NW'(div_res.rem != '0);
                    waste_next  = (div_res.rem == '0) ? '0 : FSIZE_W'(fs_eff - div_res.rem);
                    state_next  = S_CHECK;
                end
            end

            S_CHECK: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    mfv_next   = 1'b0;
                    mfn_next   = '0;
                    mfc_next   = '0;
                    mwb_next   = '0;
                    mfl_next   = 8'(free_reg);
                    mlast_next = 1'b1;
                    state_next = S_IDLE;
                    if (frames_reg > NW'(free_reg)) begin
                        mst_next = ST_NO_FRAMES;
                    end else if (frames_reg > NW'(FRAMES_PER_PROC)) begin
                        mst_next = ST_TOO_BIG;
                    end else if (pcnt_reg >= PCW'(MAX_PROCS)) begin
                        mst_next = ST_TABLE_FULL;
                    end else begin
                        mst_next  = ST_OK;
                        ent_we    = 1'b1;
                        slot_next = PW'(pcnt_reg);
                        pcnt_next = pcnt_reg + 1'b1;
                        free_next = free_reg - CW'(frames_reg);
                        if (frames_reg != '0) begin
                            // no result here: frames follow from the scan
                            mv_next    = mv_reg && !m_ready;
                            idx_next   = '0;
                            acnt_next  = '0;
                            state_next = S_ALLOC;
                        end
                    end
                end
            end

            S_ALLOC: begin
                // take the lowest free frames, one result per frame taken
                if (in_use_reg[fidx]) begin
                    idx_next = idx_reg + 1'b1;
                end else if (out_free) begin
                    in_use_next[fidx] = 1'b1;
                    own_we     = 1'b1;
                    mv_next    = 1'b1;
                    mst_next   = ST_OK;
                    mfv_next   = 1'b1;
                    mfn_next   = 7'(fidx);
                    mfc_next   = 6'(frames_reg);
                    mwb_next   = waste_reg;
                    mfl_next   = 8'(free_reg);
                    mlast_next = (NW'(acnt_reg) + NW'(1)) == frames_reg;
                    acnt_next  = acnt_reg + 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    if (mlast_next) begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_FIND: begin
                if (!ph_reg) begin
                    if (idx_reg < IW'(pcnt_reg)) begin
                        ph_next = 1'b1;
                    end else if (out_free) begin
                        mv_next    = 1'b1;
                        mst_next   = ST_NOT_FOUND;
                        mfv_next   = 1'b0;
                        mfn_next   = '0;
                        mfc_next   = '0;
                        mwb_next   = '0;
                        mfl_next   = 8'(free_reg);
                        mlast_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end else begin
                    ph_next = 1'b0;
                    if (pid_rd_reg == pid_reg) begin
                        slot_next   = PW'(idx_reg);
                        frames_next = NW'(efr_rd_reg);
                        waste_next  = wst_rd_reg;
                        acc_next    = '0;
                        idx_next    = '0;
                        state_next  = S_FREE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            S_FREE: begin
                // release the owner's frames, renumber owners above the gap
                if (!ph_reg && in_use_reg[fidx]) begin
                    ph_next = 1'b1;
                end else begin
                    ph_next = 1'b0;
                    if (ph_reg) begin
                        if (own_rd_reg == slot_reg) begin
                            in_use_next[fidx] = 1'b0;
                            if (CW'(fidx) < lim) begin
                                acc_next = acc_reg + 1'b1;
                            end
                        end else if (own_rd_reg > slot_reg) begin
                            own_we = 1'b1;
                            own_wd = own_rd_reg - 1'b1;
                        end
                    end
                    idx_next = idx_reg + 1'b1;
                    if (fidx == FW'(NUM_FRAMES - 1)) begin
                        idx_next   = IW'(slot_reg);
                        state_next = S_SHIFT;
                    end
                end
            end

            S_SHIFT: begin
                // close the gap: move each later entry down by one
                if ((idx_reg + 1'b1) < IW'(pcnt_reg)) begin
                    if (!ph_reg) begin
                        ph_next = 1'b1;
                    end else begin
                        ph_next  = 1'b0;
                        ent_we   = 1'b1;
                        ent_wa   = PW'(idx_reg);
                        ent_wpid = pid_rd_reg;
                        ent_wfr  = efr_rd_reg;
                        ent_wws  = wst_rd_reg;
                        idx_next = idx_reg + 1'b1;
                    end
                end else begin
                    pcnt_next  = pcnt_reg - 1'b1;
                    free_next  = free_reg + acc_reg;
                    state_next = S_DEL_RESP;
                end
            end

            S_DEL_RESP: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    mst_next   = ST_OK;
                    mfv_next   = 1'b0;
                    mfn_next   = '0;
                    mfc_next   = 6'(frames_reg);
                    mwb_next   = waste_reg;
                    mfl_next   = 8'(free_reg);
                    mlast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // free count can never exceed the frames that exist
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_reg <= CW'(NUM_FRAMES))
        else $error("free frame count above frame total");

    // table never holds more processes than it has entries
    a_pcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pcnt_reg <= PCW'(MAX_PROCS))
        else $error("process count above table depth");

    // an accepted item keeps the input closed on the next cycle
    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input reopened right after accepting an item");

    // only frame results may be followed by more results of the same item
    a_nonframe_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_frame_valid) |-> m_last)
        else $error("result without frame is not last");

endmodule

// File: tb/sv/tb_paged_frame_allocator.sv
`timescale 1ns / 100ps
// Self-checking testbench for paged_frame_allocator: create and delete requests
// against an in-bench allocator predictor, with random idling on both channels.
// Depends on pfa_pkg and the paged_frame_allocator RTL.
module tb_paged_frame_allocator;
    import pfa_pkg::*;

    localparam int N_FRAMES   = 128;
    localparam int N_PROCS    = 64;
    localparam int PER_PROC   = 32;
    localparam int IDLE_LIMIT = 20000;   // cycles without any handshake
    localparam int SETTLE     = 300;     // covers a full recount pass

    typedef struct {
        logic        kind;
        logic [15:0] pid;
        logic [19:0] nbytes;
    } request_t;

    typedef struct {
        logic [2:0]  status;
        logic        fvalid;
        logic [6:0]  fnum;
        logic [5:0]  fcount;
        logic [15:0] waste;
        logic [7:0]  free;
        logic        last;
    } grant_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_req_type = 1'b0;
    logic [15:0] s_proc_id = '0;
    logic [19:0] s_proc_bytes = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [2:0] m_status;
    logic m_frame_valid;
    logic [6:0] m_frame_number;
    logic [5:0] m_frame_count;
    logic [15:0] m_wasted_bytes;
    logic [7:0] m_free_left;
    logic m_last;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_SIZE;
    logic [15:0] cfg_data = '0;

    paged_frame_allocator u_dut (.*);

    always #10 aclk = ~aclk;

    // Allocator state as the predictor sees it.
    bit          frame_busy [N_FRAMES];
    logic [15:0] tbl_pid    [N_PROCS];
    int          tbl_frames [N_PROCS];
    int          tbl_waste  [N_PROCS];
    int          tbl_list   [N_PROCS][PER_PROC];
    int          proc_cnt;
    int          free_cnt;
    int          fsize;
    int          fmem;

    request_t pending_reqs[$];
    grant_t   expected_grants[$];
    logic [15:0] live_pids[$];     // generator's guess of which ids exist

    int send_idle_pct;
    int recv_stall_pct;
    int fails;
    int quiet_cycles;
    int gen_fsize;
    request_t cur_req;
    logic next_valid;

    function automatic int usable_frames();
        return (fmem > N_FRAMES) ? N_FRAMES : fmem;
    endfunction

    function automatic void recount_free();
        free_cnt = 0;
        for (int i = 0; i < usable_frames(); i++)
            if (!frame_busy[i]) free_cnt++;
    endfunction

    function automatic void push_grant(logic [2:0] st, logic fv, int fn, int cnt, int w,
                                       logic lst);
        grant_t g;
        g.status = st;
        g.fvalid = fv;
        g.fnum   = fn[6:0];
        g.fcount = cnt[5:0];
        g.waste  = w[15:0];
        g.free   = free_cnt[7:0];
        g.last   = lst;
        expected_grants.push_back(g);
    endfunction

    // Advance the allocator state by one accepted request and queue its grants.
    function automatic void predict_grants(request_t r);
        int fs, frames, wasted, j, hit, nfr, w;
        fs = (fsize == 0) ? 1 : fsize;
        if (r.kind == REQ_CREATE) begin
            frames = (int'(r.nbytes) + fs - 1) / fs;
            wasted = frames * fs - int'(r.nbytes);
            if (frames > free_cnt) begin
                push_grant(ST_NO_FRAMES, 1'b0, 0, 0, 0, 1'b1);
            end else if (frames > PER_PROC) begin
                push_grant(ST_TOO_BIG, 1'b0, 0, 0, 0, 1'b1);
            end else if (proc_cnt >= N_PROCS) begin
                push_grant(ST_TABLE_FULL, 1'b0, 0, 0, 0, 1'b1);
            end else begin
                tbl_pid[proc_cnt]    = r.pid;
                tbl_frames[proc_cnt] = frames;
                tbl_waste[proc_cnt]  = wasted;
                j = 0;
                for (int i = 0; i < usable_frames() && j < frames; i++) begin
                    if (!frame_busy[i]) begin
                        frame_busy[i] = 1'b1;
                        tbl_list[proc_cnt][j] = i;
                        j++;
                    end
                end
                free_cnt -= frames;
                if (frames == 0)
                    push_grant(ST_OK, 1'b0, 0, 0, 0, 1'b1);
                for (int k = 0; k < frames; k++)
                    push_grant(ST_OK, 1'b1, tbl_list[proc_cnt][k], frames, wasted,
                               k + 1 == frames);
                proc_cnt++;
            end
        end else begin
            hit = -1;
            for (int i = proc_cnt - 1; i >= 0; i--)
                if (tbl_pid[i] == r.pid) hit = i;
            if (hit < 0) begin
                push_grant(ST_NOT_FOUND, 1'b0, 0, 0, 0, 1'b1);
            end else begin
                nfr = tbl_frames[hit];
                w   = tbl_waste[hit];
                // Frames above the current limit are released but not counted free.
                for (int k = 0; k < nfr; k++) begin
                    if (frame_busy[tbl_list[hit][k]]) begin
                        frame_busy[tbl_list[hit][k]] = 1'b0;
                        if (tbl_list[hit][k] < usable_frames()) free_cnt++;
                    end
                end
                for (int k = hit; k + 1 < proc_cnt; k++) begin
                    tbl_pid[k]    = tbl_pid[k + 1];
                    tbl_frames[k] = tbl_frames[k + 1];
                    tbl_waste[k]  = tbl_waste[k + 1];
                    tbl_list[k]   = tbl_list[k + 1];
                end
                proc_cnt--;
                push_grant(ST_OK, 1'b0, 0, nfr, w, 1'b1);
            end
        end
    endfunction

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fails++;
        end
    endfunction

    // Driver: predict on acceptance, then load the next item unless idling.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                predict_grants(cur_req);
                next_valid = 1'b0;
            end
            if (!next_valid && pending_reqs.size() > 0
                && $urandom_range(0, 99) >= send_idle_pct) begin
                cur_req      = pending_reqs.pop_front();
                s_req_type   <= cur_req.kind;
                s_proc_id    <= cur_req.pid;
                s_proc_bytes <= cur_req.nbytes;
                next_valid   = 1'b1;
            end
            s_valid <= next_valid;
        end
    end

    // Monitor: compare each accepted grant with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_grants.size() == 0) begin
                $error("unexpected result item: status %0d frame %0d", m_status,
                       m_frame_number);
                fails++;
            end else begin
                grant_t g;
                g = expected_grants.pop_front();
                check_field("status", int'(g.status), int'(m_status));
                check_field("frame_valid", int'(g.fvalid), int'(m_frame_valid));
                check_field("frame_number", int'(g.fnum), int'(m_frame_number));
                check_field("frame_count", int'(g.fcount), int'(m_frame_count));
                check_field("wasted_bytes", int'(g.waste), int'(m_wasted_bytes));
                check_field("free_left", int'(g.free), int'(m_free_left));
                check_field("last", int'(g.last), int'(m_last));
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog: end the run when no channel moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!(cfg_valid && cfg_ready)) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_FRAME_SIZE) begin
            fsize = int'(val);
        end else begin
            fmem = int'(val[7:0]);
            recount_free();
        end
    endtask

    task automatic queue_req(logic kind, logic [15:0] pid, logic [19:0] nbytes);
        request_t r;
        r.kind = kind;
        r.pid = pid;
        r.nbytes = nbytes;
        pending_reqs.push_back(r);
    endtask

    // Hold until everything queued is accepted and every grant has arrived.
    task automatic drain();
        while (pending_reqs.size() > 0 || s_valid || expected_grants.size() > 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Mostly creates and deletes of live ids; some noise ids and wild sizes.
    task automatic queue_random(int count, int del_pct);
        int pick;
        logic [15:0] pid;
        logic [19:0] nbytes;
        for (int n = 0; n < count; n++) begin
            if (live_pids.size() > 0 && $urandom_range(0, 99) < del_pct) begin
                if ($urandom_range(0, 99) < 85) begin
                    pick = $urandom_range(0, live_pids.size() - 1);
                    pid = live_pids[pick];
                    live_pids.delete(pick);
                end else begin
                    pid = 16'($urandom);
                end
                queue_req(REQ_DELETE, pid, 20'($urandom));
            end else begin
                pid = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 31))
                                                   : 16'($urandom);
                if ($urandom_range(0, 99) < 15)
                    nbytes = 20'($urandom);
                else
                    nbytes = 20'($urandom_range(0, gen_fsize * 6));
                queue_req(REQ_CREATE, pid, nbytes);
                live_pids.push_back(pid);
            end
        end
    endtask

    initial begin
        fails = 0;
        quiet_cycles = 0;
        send_idle_pct = 17;
        recv_stall_pct = 85;
        fsize = int'(FSIZE_RESET);
        fmem = int'(FIM_RESET);
        proc_cnt = 0;
        for (int i = 0; i < N_FRAMES; i++) frame_busy[i] = 1'b0;
        recount_free();
        gen_fsize = 4096;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero size, exact and partial frames, full process, errors,
        // duplicate ids and deletes of absent ids, all at reset settings.
        queue_req(REQ_CREATE, 16'd1, 20'd0);
        queue_req(REQ_CREATE, 16'd2, 20'd1);
        queue_req(REQ_CREATE, 16'd3, 20'd4096);
        queue_req(REQ_CREATE, 16'd4, 20'd4097);
        queue_req(REQ_CREATE, 16'd5, 20'd131072);
        queue_req(REQ_CREATE, 16'd6, 20'd135168);
        queue_req(REQ_CREATE, 16'd7, 20'hFFFFF);
        queue_req(REQ_CREATE, 16'hFFFF, 20'd100);
        queue_req(REQ_CREATE, 16'd2, 20'd5);
        queue_req(REQ_DELETE, 16'd2, 20'd0);
        queue_req(REQ_DELETE, 16'd2, 20'hFFFFF);
        queue_req(REQ_DELETE, 16'd2, 20'd0);
        queue_req(REQ_DELETE, 16'd0, 20'd0);
        queue_req(REQ_DELETE, 16'd5, 20'd0);
        queue_req(REQ_DELETE, 16'hFFFF, 20'd0);
        queue_req(REQ_DELETE, 16'd1, 20'd0);
        queue_req(REQ_DELETE, 16'd3, 20'd0);
        queue_req(REQ_DELETE, 16'd4, 20'd0);
        drain();

        queue_random(110, 40);
        drain();

        // Shrink the limit while frames are still owned; one byte per frame.
        send_idle_pct = 85;
        recv_stall_pct = 17;
        write_reg(CFG_FRAME_SIZE, 16'd1);
        write_reg(CFG_FRAMES_MEM, 16'd40);
        gen_fsize = 1;
        queue_random(100, 45);
        drain();

        // Largest frame size, limit saturated; fill the process table.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(CFG_FRAME_SIZE, 16'hFFFF);
        write_reg(CFG_FRAMES_MEM, 16'd200);
        gen_fsize = 65535;
        for (int n = 0; n < 70; n++)
            queue_req(REQ_CREATE, 16'($urandom), 20'($urandom_range(0, 3)));
        queue_random(50, 60);
        drain();

        // Zero frame size and no usable memory: frees go uncounted.
        write_reg(CFG_FRAME_SIZE, 16'd0);
        write_reg(CFG_FRAMES_MEM, 16'd0);
        gen_fsize = 1;
        queue_random(40, 60);
        drain();

        write_reg(CFG_FRAME_SIZE, FSIZE_RESET);
        write_reg(CFG_FRAMES_MEM, {8'h00, FIM_RESET});
        gen_fsize = 4096;
        queue_random(80, 45);
        drain();

        if (fails == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
